>>> src/aflt_pkg.sv
package aflt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] ACT_CHECK   = 3'd0;
    localparam logic [2:0] ACT_SUCCESS = 3'd1;
    localparam logic [2:0] ACT_FAILURE = 3'd2;
    localparam logic [2:0] ACT_QUERY   = 3'd3;
    localparam logic [2:0] ACT_RESET1  = 3'd4;
    localparam logic [2:0] ACT_RESETA  = 3'd5;
    localparam logic [2:0] ACT_CLEANUP = 3'd6;

    localparam logic [2:0] CFG_LIMIT   = 3'd0;
    localparam logic [2:0] CFG_INITIAL = 3'd1;
    localparam logic [2:0] CFG_FACTOR  = 3'd2;
    localparam logic [2:0] CFG_CEILING = 3'd3;
    localparam logic [2:0] CFG_IDLE    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LOCKED = 2'd1;
    localparam logic [1:0] ST_RELOCK = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] ident;
        logic [7:0]  failures;
        logic [47:0] last_attempt;
        logic [47:0] lock_until;
        logic [31:0] backoff;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_EXEC, S_MUL, S_OUT
    } fsm_t;

endpackage

>>> src/auth_failure_lockout_table_top.sv
// Flow: the request is registered in idle, then the walk reads the record memory entry by entry;
// a wait state and the execute step follow, with a multiply step added for a failure on an
// identifier that already has a record; the result is registered and held until it is taken.
// Throughput: one transaction at a time; the memory walk reads one entry per cycle.
// Reset: asynchronous active low; control and configuration registers return to their reset
// values, valid bits clear, so the table is empty immediately and no clearing pass is needed.
module auth_failure_lockout_table_top
    import aflt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] ident,
    input  logic [47:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        allowed,
    output logic [31:0] wait_ms,
    output logic signed [8:0] attempts_left,
    output logic [1:0]  status,
    output logic        locked,
    output logic [7:0]  fail_total,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  limit_reg;
    logic [31:0] initial_reg;
    logic [12:0] factor_reg;
    logic [31:0] ceiling_reg;
    logic [31:0] idle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= 8'd5;
            initial_reg <= 32'd1000;
            factor_reg  <= 13'd512;
            ceiling_reg <= 32'd300000;
            idle_reg    <= 32'd600000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT:   limit_reg   <= cfg_data[7:0];
                CFG_INITIAL: initial_reg <= cfg_data;
                CFG_FACTOR:  factor_reg  <= cfg_data[12:0];
                CFG_CEILING: ceiling_reg <= cfg_data;
                CFG_IDLE:    idle_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request registers.
    logic [2:0]  act_reg;
    logic [31:0] id_reg;
    logic [47:0] now_reg;

    fsm_t state_reg, state_next;
    logic [CNT_W-1:0] scan_reg;          // read address of the walk, counts to the depth
    logic [IDX_W-1:0] chk_reg;           // entry whose data is on the read port
    logic             chk_live_reg;
    logic             hit_reg, free_ok_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    rec_t rd_data;
    rec_t rec_reg;                       // record being modified
    logic [44:0] prod_reg;               // backoff times factor, registered
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t        wr_data;

    // The memory walk reads every entry once; cleanup frees stale entries as
    // they stream past, and the identifier search records the matching slot.
    logic rd_en;
    assign rd_en = (state_reg == S_SCAN) && (scan_reg < CNT_W'(TABLE_ENTRIES));

    aflt_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    logic [47:0] thr;
    logic        thr_ok;
    assign thr_ok = now_reg >= {16'd0, idle_reg};
    assign thr    = now_reg - {16'd0, idle_reg};

    // Result registers.
    logic        allowed_reg;
    logic [31:0] wait_reg;
    logic [8:0]  left_reg;
    logic [1:0]  status_reg;
    logic        locked_reg;
    logic [7:0]  total_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SCAN;
            S_SCAN: if (scan_reg == CNT_W'(TABLE_ENTRIES)) state_next = S_WAIT;
            S_WAIT: state_next = S_EXEC;
            S_EXEC: state_next = (act_reg == ACT_FAILURE && hit_reg) ? S_MUL : S_OUT;
            S_MUL:  state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
    end

    assign allowed       = allowed_reg;
    assign wait_ms       = wait_reg;
    assign attempts_left = left_reg;
    assign status        = status_reg;
    assign locked        = locked_reg;
    assign fail_total    = total_reg;

    // Record arithmetic for the execute step.
    logic [47:0] remain48;
    logic [31:0] remain;
    logic [48:0] lock_sum;
    logic [47:0] lock_new;
    logic        idle_hit;
    logic [7:0]  cnt_inc;
    logic [31:0] b_grow, b_new;
    logic [31:0] init_cap;
    logic [31:0] b_fail;
    logic [7:0]  cnt_fail;
    logic [8:0]  left_calc;
    logic [48:0] f_sum;
    logic [47:0] f_sum_lock;

    always_comb
    begin
        remain48 = (rec_reg.lock_until > now_reg) ? rec_reg.lock_until - now_reg : 48'd0;
        remain   = (remain48 > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : remain48[31:0];
        idle_hit = (rec_reg.last_attempt != 48'd0) && (now_reg > rec_reg.last_attempt)
                   && ((now_reg - rec_reg.last_attempt) > {16'd0, idle_reg});
        cnt_inc  = rec_reg.failures + 8'd1;
        init_cap = (initial_reg > ceiling_reg) ? ceiling_reg : initial_reg;
        b_grow   = (prod_reg[44:8] > {5'd0, ceiling_reg}) ? ceiling_reg : prod_reg[39:8];
        if (rec_reg.failures == 8'd255)
            b_new = rec_reg.backoff;
        else if (rec_reg.failures == 8'd0)
            b_new = init_cap;
        else
            b_new = b_grow;
        // A failure on a fresh record always starts at one failure and the first backoff.
        b_fail   = hit_reg ? b_new : init_cap;
        if (!hit_reg)
            cnt_fail = 8'd1;
        else if (rec_reg.failures == 8'd255)
            cnt_fail = rec_reg.failures;
        else
            cnt_fail = cnt_inc;
        lock_sum  = {1'b0, now_reg} + {17'd0, rec_reg.backoff};
        lock_new  = lock_sum[48] ? MAX48 : lock_sum[47:0];
        left_calc = {1'b0, limit_reg} - {1'b0, rec_reg.failures};
        // Lock end of a failure that reaches the limit.
        f_sum      = {1'b0, now_reg} + {17'd0, b_fail};
        f_sum_lock = f_sum[48] ? MAX48 : f_sum[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            act_reg <= action;
            id_reg  <= ident;
            now_reg <= now_ms;
        end
        if (state_reg == S_SCAN && chk_live_reg && valid_reg[chk_reg[IDX_W-1:0]]
            && rd_data.ident == id_reg)
        begin
            rec_reg <= rd_data;
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg <= rec_reg.backoff * factor_reg;
        end
    end

    // Write port and record update.
    rec_t upd;
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        upd     = rec_reg;
        if (state_reg == S_EXEC)
        begin
            unique case (act_reg)
                ACT_CHECK:
                begin
                    if (hit_reg && idle_hit)
                    begin
                        upd   = '{ident: id_reg, default: '0};
                        wr_en = 1'b1;
                    end
                    else if (hit_reg && !(rec_reg.lock_until > now_reg)
                             && rec_reg.failures >= limit_reg)
                    begin
                        upd.lock_until = lock_new;
                        wr_en = 1'b1;
                    end
                end
                ACT_SUCCESS:
                begin
                    upd   = '{ident: id_reg, default: '0};
                    wr_en = hit_reg;
                end
                ACT_FAILURE:
                begin
                    if (!hit_reg && free_ok_reg)
                    begin
                        upd = '{ident: id_reg, default: '0};
                        upd.failures     = cnt_fail;
                        upd.backoff      = b_fail;
                        upd.last_attempt = now_reg;
                        if (cnt_fail >= limit_reg)
                            upd.lock_until = f_sum_lock;
                        wr_addr = free_idx_reg;
                        wr_en   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == S_MUL)
        begin
            upd.failures     = cnt_fail;
            upd.backoff      = b_fail;
            upd.last_attempt = now_reg;
            if (cnt_fail >= limit_reg)
                upd.lock_until = f_sum_lock;
            wr_en = 1'b1;
        end
        wr_data = upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            scan_reg     <= '0;
            chk_reg      <= '0;
            chk_live_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_ok_reg  <= 1'b0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    scan_reg     <= '0;
                    chk_live_reg <= 1'b0;
                    hit_reg      <= 1'b0;
                    free_ok_reg  <= 1'b0;
                end
                S_SCAN:
                begin
                    chk_live_reg <= rd_en;
                    chk_reg      <= scan_reg[IDX_W-1:0];
                    if (rd_en)
                        scan_reg <= scan_reg + CNT_W'(1);
                    if (chk_live_reg)
                    begin
                        if (valid_reg[chk_reg[IDX_W-1:0]] && rd_data.ident == id_reg
                            && !hit_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= chk_reg[IDX_W-1:0];
                        end
                        if (!valid_reg[chk_reg[IDX_W-1:0]] && !free_ok_reg)
                        begin
                            free_ok_reg  <= 1'b1;
                            free_idx_reg <= chk_reg[IDX_W-1:0];
                        end
                        if (act_reg == ACT_CLEANUP && thr_ok
                            && rd_data.last_attempt < thr)
                            valid_reg[chk_reg[IDX_W-1:0]] <= 1'b0;
                    end
                end
                S_WAIT: ;
                S_EXEC:
                begin
                    if (act_reg == ACT_RESET1 && hit_reg)
                        valid_reg[hit_idx_reg] <= 1'b0;
                    if (act_reg == ACT_RESETA)
                        valid_reg <= '0;
                    if (act_reg == ACT_FAILURE && !hit_reg && free_ok_reg)
                        valid_reg[free_idx_reg] <= 1'b1;
                end
                S_MUL: ;
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Result formation; a new failure for an unknown identifier finishes in the
    // execute step, a known one in the multiply step.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC || state_reg == S_MUL)
        begin
            allowed_reg <= 1'b0;
            wait_reg    <= '0;
            left_reg    <= '0;
            status_reg  <= ST_OK;
            locked_reg  <= 1'b0;
            total_reg   <= '0;
            if (state_reg == S_MUL
                || (act_reg == ACT_FAILURE && !hit_reg && free_ok_reg))
            begin
                total_reg <= upd.failures;
                if (upd.failures >= limit_reg)
                begin
                    wait_reg   <= upd.backoff;
                    status_reg <= ST_LOCKED;
                    left_reg   <= 9'h1FF;
                    locked_reg <= f_sum_lock > now_reg;
                end
                else
                begin
                    left_reg   <= {1'b0, limit_reg} - {1'b0, upd.failures};
                    locked_reg <= upd.lock_until > now_reg;
                end
            end
            else
            begin
                unique case (act_reg)
                    ACT_CHECK:
                    begin
                        if (!hit_reg || idle_hit)
                        begin
                            allowed_reg <= 1'b1;
                            left_reg    <= {1'b0, limit_reg};
                        end
                        else
                        begin
                            total_reg <= rec_reg.failures;
                            if (rec_reg.lock_until > now_reg)
                            begin
                                wait_reg   <= remain;
                                left_reg   <= 9'h1FF;
                                status_reg <= ST_LOCKED;
                                locked_reg <= 1'b1;
                            end
                            else if (rec_reg.failures >= limit_reg)
                            begin
                                wait_reg   <= rec_reg.backoff;
                                status_reg <= ST_RELOCK;
                                locked_reg <= rec_reg.backoff != 32'd0;
                            end
                            else
                            begin
                                allowed_reg <= 1'b1;
                                left_reg    <= left_calc;
                            end
                        end
                    end
                    ACT_FAILURE: status_reg <= ST_FULL;
                    ACT_QUERY:
                    begin
                        if (hit_reg)
                        begin
                            locked_reg <= rec_reg.lock_until > now_reg;
                            wait_reg   <= remain;
                            total_reg  <= rec_reg.failures;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> src/aflt_store.sv
module aflt_store
    import aflt_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rec_t             rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rec_t             wr_data
);

    rec_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
